// ===== hw/rtl/cfel_pkg.sv =====
// ----------------------------------------------------------------------------
// cfel_pkg: shared types and constants for the free extent list
// Sizes of the extent table and of addresses and lengths, the table entry
// type, result status codes and the sequencer states.
// ----------------------------------------------------------------------------
package cfel_pkg;

  localparam int HOLE_SLOTS  = 16;
  localparam int ALIGN_BYTES = 16;   // power of two
  localparam int ADDR_BITS   = 48;
  localparam int LEN_BITS    = 40;

  localparam int IDX_W = (HOLE_SLOTS > 1) ? $clog2(HOLE_SLOTS) : 1;
  localparam int CNT_W = $clog2(HOLE_SLOTS + 1);
  localparam int AW1   = ADDR_BITS + 1;
  localparam int AW2   = ADDR_BITS + 2;
  localparam int LW1   = LEN_BITS + 1;
  localparam int LW2   = LEN_BITS + 2;

  localparam logic [ADDR_BITS-1:0] ALIGN_MASK = ADDR_BITS'(ALIGN_BYTES - 1);

  localparam logic REQ_TAKE    = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [LEN_BITS-1:0]  len;
  } entry_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_FRAGMENTED = 2'd2,
    ST_OVERLAP    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_RSCAN,
    S_RDEC1,
    S_RDEC2,
    S_TA,
    S_TB,
    S_TACT,
    S_CLOSE,
    S_OPEN,
    S_INS,
    S_FINISH
  } state_t;

endpackage

// ===== hw/rtl/cfel_ifs.sv =====
// ----------------------------------------------------------------------------
// cfel request / response channels
// Valid/ready channels carrying one request or one result transaction.
// ----------------------------------------------------------------------------
interface cfel_req_if import cfel_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [ADDR_BITS-1:0] range_start;
  logic [LEN_BITS-1:0]  byte_count;

  modport source (output valid, req_type, range_start, byte_count, input ready);
  modport sink   (input valid, req_type, range_start, byte_count, output ready);
endinterface

interface cfel_rsp_if import cfel_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [ADDR_BITS-1:0] grant_address;
  logic [CNT_W-1:0]     holes_in_use;

  modport source (output valid, status, grant_address, holes_in_use, input ready);
  modport sink   (input valid, status, grant_address, holes_in_use, output ready);
endinterface

// ===== hw/rtl/coalescing_free_extent_list.sv =====
// ----------------------------------------------------------------------------
// coalescing_free_extent_list: address-ordered free extent table
// First-fit allocator over up to HOLE_SLOTS free extents with merging on
// release and head/tail split on take, run by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   req  - one transaction per request: req_type (0 take, 1 release),
//          range_start (release only) and byte_count.
//   rsp  - exactly one transaction per request: status, grant_address
//          (aligned start on a good take, else zero) and holes_in_use.
// Extents live in a small entry memory (one write, one registered read port).
// The sequencer walks it one entry at a time and also uses it to shift
// entries when a slot is opened or closed.
// Steps per request:
//   release : scan one entry per cycle, then decide (S_RDEC1, S_RDEC2) and shift
//   take    : align (S_TA) and fit check (S_TB) per entry, then split and shift
// req.ready is high only while the sequencer is idle; one request is in
// flight at a time. The result sits in an output register, so a new request
// may be taken while rsp stalls; the following result then waits for it.
// Reset empties the table (count to zero) and drops any pending result.
// ----------------------------------------------------------------------------
module coalescing_free_extent_list import cfel_pkg::*; (
  input logic        clk,
  input logic        rst,
  cfel_req_if.sink   req,
  cfel_rsp_if.source rsp
);

  // extent memory
  entry_t mem [HOLE_SLOTS];
  entry_t rd_data;
  logic [CNT_W-1:0] rd_ptr;
  logic             mem_we;
  logic [CNT_W-1:0] mem_wa;
  entry_t           mem_wd;

  // control registers
  state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic out_valid, out_valid_next;

  // working registers
  logic [CNT_W-1:0] idx, idx_next;       // scan position / insertion point
  logic [CNT_W-1:0] sh, sh_next;         // shift cursor
  logic [CNT_W-1:0] lim, lim_next;       // shift end (old count)
  logic [CNT_W-1:0] ins_at, ins_at_next;
  entry_t           ins, ins_next;
  logic             kind, kind_next;
  logic [ADDR_BITS-1:0] s_reg, s_next;
  logic [LEN_BITS-1:0]  len_reg, len_next;
  logic [AW1-1:0]   e_reg, e_next;       // release end, one bit of headroom
  entry_t           prev, prev_next;     // entry before the insertion point
  logic [AW1-1:0]   prev_end, prev_end_next;
  entry_t           cur, cur_next;       // entry at the insertion / fit point
  logic [LW1-1:0]   sum_b, sum_b_next;
  logic [LW1-1:0]   sum_a, sum_a_next;
  logic             jb, jb_next;
  logic             ja, ja_next;
  logic [AW1-1:0]   astart, astart_next;
  logic [AW1-1:0]   hend, hend_next;
  logic [AW1-1:0]   aend, aend_next;
  logic [LEN_BITS-1:0] pad, pad_next;
  status_t          res_status, res_status_next;
  logic [ADDR_BITS-1:0] res_grant, res_grant_next;
  status_t          out_status, out_status_next;
  logic [ADDR_BITS-1:0] out_grant, out_grant_next;
  logic [CNT_W-1:0] out_holes, out_holes_next;

  // combinational terms
  logic [AW1-1:0]       hend_c;
  logic [ADDR_BITS-1:0] pad_c;
  logic [AW2-1:0]       aend_c;
  logic [LW2-1:0]       sum_ab_c;
  logic                 ja_eff;
  logic                 head;
  logic                 tail_nz;
  logic [LEN_BITS-1:0]  tail_c;
  logic                 fit;

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.grant_address = out_grant;
  assign rsp.holes_in_use  = out_holes;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa[IDX_W-1:0]] <= mem_wd;
    end
    rd_data <= mem[rd_ptr[IDX_W-1:0]];
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    out_valid_next  = out_valid;
    idx_next        = idx;
    sh_next         = sh;
    lim_next        = lim;
    ins_at_next     = ins_at;
    ins_next        = ins;
    kind_next       = kind;
    s_next          = s_reg;
    len_next        = len_reg;
    e_next          = e_reg;
    prev_next       = prev;
    prev_end_next   = prev_end;
    cur_next        = cur;
    sum_b_next      = sum_b;
    sum_a_next      = sum_a;
    jb_next         = jb;
    ja_next         = ja;
    astart_next     = astart;
    hend_next       = hend;
    aend_next       = aend;
    pad_next        = pad;
    res_status_next = res_status;
    res_grant_next  = res_grant;
    out_status_next = out_status;
    out_grant_next  = out_grant;
    out_holes_next  = out_holes;
    mem_we          = 1'b0;
    mem_wa          = idx;
    mem_wd          = rd_data;
    rd_ptr          = idx;

    hend_c   = AW1'(rd_data.start) + AW1'(rd_data.len);
    pad_c    = (~rd_data.start + ADDR_BITS'(1)) & ALIGN_MASK;
    aend_c   = AW2'(astart) + AW2'(len_reg);
    fit      = !astart[ADDR_BITS] && (aend_c <= AW2'(hend));
    sum_ab_c = LW2'(sum_b) + LW2'(cur.len);
    ja_eff   = ja && !(jb && (sum_ab_c[LW2-1:LEN_BITS] != 2'b00));
    head     = (pad != '0);
    tail_nz  = (hend != aend);
    tail_c   = LEN_BITS'(hend - aend);

    if (out_valid && rsp.ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          kind_next      = req.req_type;
          s_next         = req.range_start;
          len_next       = req.byte_count;
          e_next         = AW1'(req.range_start) + AW1'(req.byte_count);
          res_grant_next = '0;
          state_next     = S_PREP;
        end
      end

      S_PREP: begin
        idx_next = '0;
        rd_ptr   = '0;
        if (kind == REQ_RELEASE) begin
          if (len_reg == '0) begin
            res_status_next = ST_OK;
            state_next      = S_FINISH;
          end else if (e_reg[ADDR_BITS]) begin
            res_status_next = ST_OVERLAP;       // runs past the address space
            state_next      = S_FINISH;
          end else if (cnt == '0) begin
            state_next = S_RDEC1;
          end else begin
            state_next = S_RSCAN;
          end
        end else begin
          if (len_reg == '0 || cnt == '0) begin
            res_status_next = ST_NO_SPACE;
            state_next      = S_FINISH;
          end else begin
            state_next = S_TA;
          end
        end
      end

      // release: one entry per cycle, next read issued ahead
      S_RSCAN: begin
        rd_ptr = idx + 1'b1;
        if (AW1'(s_reg) < hend_c && AW1'(rd_data.start) < e_reg) begin
          res_status_next = ST_OVERLAP;
          state_next      = S_FINISH;
        end else if (AW1'(rd_data.start) >= e_reg) begin
          cur_next   = rd_data;
          state_next = S_RDEC1;
        end else begin
          prev_next     = rd_data;
          prev_end_next = hend_c;
          idx_next      = idx + 1'b1;
          if (idx + 1'b1 == cnt) begin
            state_next = S_RDEC1;
          end
        end
      end

      S_RDEC1: begin
        sum_b_next = LW1'(prev.len) + LW1'(len_reg);
        sum_a_next = LW1'(cur.len) + LW1'(len_reg);
        jb_next    = (idx != '0) && (prev_end == AW1'(s_reg)) && !sum_b_next[LEN_BITS];
        ja_next    = (idx < cnt) && (AW1'(cur.start) == e_reg) && !sum_a_next[LEN_BITS];
        state_next = S_RDEC2;
      end

      S_RDEC2: begin
        res_status_next = ST_OK;
        state_next      = S_FINISH;
        if (jb && ja_eff) begin
          mem_we   = 1'b1;
          mem_wa   = idx - 1'b1;
          mem_wd   = '{start: prev.start, len: sum_ab_c[LEN_BITS-1:0]};
          cnt_next = cnt - 1'b1;
          if (idx + 1'b1 < cnt) begin
            sh_next    = idx + 1'b1;
            lim_next   = cnt;
            rd_ptr     = idx + 1'b1;
            state_next = S_CLOSE;
          end
        end else if (jb) begin
          mem_we = 1'b1;
          mem_wa = idx - 1'b1;
          mem_wd = '{start: prev.start, len: sum_b[LEN_BITS-1:0]};
        end else if (ja_eff) begin
          mem_we = 1'b1;
          mem_wa = idx;
          mem_wd = '{start: s_reg, len: sum_a[LEN_BITS-1:0]};
        end else if (cnt == CNT_W'(HOLE_SLOTS)) begin
          res_status_next = ST_FRAGMENTED;
        end else begin
          ins_at_next = idx;
          ins_next    = '{start: s_reg, len: len_reg};
          cnt_next    = cnt + 1'b1;
          if (cnt > idx) begin
            sh_next    = cnt;
            rd_ptr     = cnt - 1'b1;
            state_next = S_OPEN;
          end else begin
            state_next = S_INS;
          end
        end
      end

      // take: align the start of the entry
      S_TA: begin
        cur_next    = rd_data;
        pad_next    = LEN_BITS'(pad_c);
        astart_next = AW1'(rd_data.start) + AW1'(pad_c);
        hend_next   = hend_c;
        state_next  = S_TB;
      end

      // take: fit check, next read issued ahead
      S_TB: begin
        rd_ptr = idx + 1'b1;
        if (fit) begin
          aend_next  = AW1'(aend_c);
          state_next = S_TACT;
        end else if (idx + 1'b1 == cnt) begin
          res_status_next = ST_NO_SPACE;
          state_next      = S_FINISH;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_TA;
        end
      end

      S_TACT: begin
        state_next = S_FINISH;
        if (head && tail_nz && cnt == CNT_W'(HOLE_SLOTS)) begin
          res_status_next = ST_FRAGMENTED;
        end else begin
          res_status_next = ST_OK;
          res_grant_next  = astart[ADDR_BITS-1:0];
          if (!head && !tail_nz) begin
            cnt_next = cnt - 1'b1;
            if (idx + 1'b1 < cnt) begin
              sh_next    = idx + 1'b1;
              lim_next   = cnt;
              rd_ptr     = idx + 1'b1;
              state_next = S_CLOSE;
            end
          end else if (!head) begin
            mem_we = 1'b1;
            mem_wa = idx;
            mem_wd = '{start: aend[ADDR_BITS-1:0], len: tail_c};
          end else begin
            mem_we = 1'b1;
            mem_wa = idx;
            mem_wd = '{start: cur.start, len: pad};
            if (tail_nz) begin
              ins_at_next = idx + 1'b1;
              ins_next    = '{start: aend[ADDR_BITS-1:0], len: tail_c};
              cnt_next    = cnt + 1'b1;
              if (cnt > idx + 1'b1) begin
                sh_next    = cnt;
                rd_ptr     = cnt - 1'b1;
                state_next = S_OPEN;
              end else begin
                state_next = S_INS;
              end
            end
          end
        end
      end

      // move entries down one slot: mem[sh-1] <= mem[sh]
      S_CLOSE: begin
        mem_we = 1'b1;
        mem_wa = sh - 1'b1;
        mem_wd = rd_data;
        rd_ptr = sh + 1'b1;
        if (sh + 1'b1 == lim) begin
          state_next = S_FINISH;
        end else begin
          sh_next = sh + 1'b1;
        end
      end

      // move entries up one slot: mem[sh] <= mem[sh-1]
      S_OPEN: begin
        mem_we = 1'b1;
        mem_wa = sh;
        mem_wd = rd_data;
        rd_ptr = sh - 2'd2;
        if (sh - 1'b1 == ins_at) begin
          state_next = S_INS;
        end else begin
          sh_next = sh - 1'b1;
        end
      end

      S_INS: begin
        mem_we     = 1'b1;
        mem_wa     = ins_at;
        mem_wd     = ins;
        state_next = S_FINISH;
      end

      S_FINISH: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_grant_next  = res_grant;
          out_holes_next  = cnt;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    sh         <= sh_next;
    lim        <= lim_next;
    ins_at     <= ins_at_next;
    ins        <= ins_next;
    kind       <= kind_next;
    s_reg      <= s_next;
    len_reg    <= len_next;
    e_reg      <= e_next;
    prev       <= prev_next;
    prev_end   <= prev_end_next;
    cur        <= cur_next;
    sum_b      <= sum_b_next;
    sum_a      <= sum_a_next;
    jb         <= jb_next;
    ja         <= ja_next;
    astart     <= astart_next;
    hend       <= hend_next;
    aend       <= aend_next;
    pad        <= pad_next;
    res_status <= res_status_next;
    res_grant  <= res_grant_next;
    out_status <= out_status_next;
    out_grant  <= out_grant_next;
    out_holes  <= out_holes_next;
  end

  // table never holds more extents than it has slots
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(HOLE_SLOTS))
    else $error("extent count above table size");

  // opening a slot never shifts below the insertion point
  a_open_cursor: assert property (@(posedge clk) disable iff (rst)
    state == S_OPEN |-> sh > ins_at)
    else $error("open-slot cursor passed insertion point");

  // a loaded result reports the table size after the request
  a_holes_match: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && (!out_valid || rsp.ready)) |=>
      (rsp.valid && rsp.holes_in_use == cnt))
    else $error("holes_in_use does not match table count");

  // only a good take carries a nonzero grant
  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_OK) |-> rsp.grant_address == '0)
    else $error("grant on refused request");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the coalescing free extent list
// Drives take and release transactions with random gaps and checks each result
// against a cycle-free model of the address-ordered extent table.
// ----------------------------------------------------------------------------
module tb_top;
  import cfel_pkg::*;

  // 64-bit views of the field limits; all model arithmetic runs at 64 bits
  localparam bit [63:0] ADDR_LIMIT     = (64'd1 << ADDR_BITS) - 64'd1;
  localparam bit [63:0] LEN_LIMIT      = (64'd1 << LEN_BITS) - 64'd1;
  localparam int        RANDOM_ITEMS   = 600;
  localparam int        WATCHDOG_LIMIT = 4000;  // covers the longest request plus stalls
  localparam int        SETTLE_CYCLES  = 80;

  typedef struct {
    bit                 kind;
    bit [ADDR_BITS-1:0] start;
    bit [LEN_BITS-1:0]  count;
    bit                 wait_drain;  // hold this one until all results are back
  } req_item_t;

  typedef struct {
    status_t            status;
    bit [ADDR_BITS-1:0] grant;
    bit [CNT_W-1:0]     holes;
  } extent_result_t;

  logic clk;
  logic rst = 1'b1;

  // Bench-side drivers, all known from time zero
  logic                 drv_valid = 1'b0;
  logic                 drv_kind  = REQ_TAKE;
  logic [ADDR_BITS-1:0] drv_start = '0;
  logic [LEN_BITS-1:0]  drv_count = '0;
  logic                 sink_ready = 1'b0;

  cfel_req_if req_if ();
  cfel_rsp_if rsp_if ();

  assign req_if.valid       = drv_valid;
  assign req_if.req_type    = drv_kind;
  assign req_if.range_start = drv_start;
  assign req_if.byte_count  = drv_count;
  assign rsp_if.ready       = sink_ready;

  coalescing_free_extent_list uut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Extent table model: sorted by start, only entries below ext_count valid
  // --------------------------------------------------------------------------
  bit [ADDR_BITS-1:0] ext_start [HOLE_SLOTS];
  bit [LEN_BITS-1:0]  ext_len   [HOLE_SLOTS];
  int unsigned        ext_count = 0;

  req_item_t      pending_reqs [$];
  extent_result_t owed_results [$];
  bit             drain_next = 1'b0;

  // Bookkeeping; the two handshake counters move by NBA so both sides read
  // a stable value at the clock edge
  int n_accepted = 0;
  int n_results  = 0;
  int n_releases = 0;
  int n_takes    = 0;
  int status_count [4];
  int unsigned peak_holes = 0;
  int mismatches = 0;

  function automatic void drop_extent(int unsigned at);
    for (int unsigned i = at; i + 1 < ext_count; i++) begin
      ext_start[i] = ext_start[i+1];
      ext_len[i]   = ext_len[i+1];
    end
    ext_count--;
  endfunction

  // Caller makes sure a slot is free
  function automatic void add_extent(int unsigned at, bit [63:0] s, bit [63:0] n);
    for (int unsigned i = ext_count; i > at; i--) begin
      ext_start[i] = ext_start[i-1];
      ext_len[i]   = ext_len[i-1];
    end
    ext_start[at] = s[ADDR_BITS-1:0];
    ext_len[at]   = n[LEN_BITS-1:0];
    ext_count++;
  endfunction

  // Insert a freed range, merging with neighbors when the length still fits
  function automatic status_t release_range(bit [63:0] s, bit [63:0] n);
    bit [63:0]   fin;
    bit [63:0]   hend;
    int unsigned at;
    bit          join_lo;
    bit          join_hi;
    if (n == 0) return ST_OK;
    if (n > ADDR_LIMIT - s) return ST_OVERLAP;  // runs off the address space
    fin = s + n;
    at  = ext_count;
    for (int unsigned i = 0; i < ext_count; i++) begin
      hend = 64'(ext_start[i]) + 64'(ext_len[i]);
      if (s < hend && 64'(ext_start[i]) < fin) return ST_OVERLAP;
      if (64'(ext_start[i]) >= fin) begin
        at = i;
        break;
      end
    end
    join_lo = 1'b0;
    join_hi = 1'b0;
    if (at > 0)
      join_lo = (64'(ext_start[at-1]) + 64'(ext_len[at-1]) == s) &&
                (64'(ext_len[at-1]) <= LEN_LIMIT - n);
    if (at < ext_count)
      join_hi = (64'(ext_start[at]) == fin) && (64'(ext_len[at]) <= LEN_LIMIT - n);
    // three-way merge too long: keep only the lower one
    if (join_lo && join_hi && 64'(ext_len[at]) > LEN_LIMIT - n - 64'(ext_len[at-1]))
      join_hi = 1'b0;
    if (join_lo && join_hi) begin
      ext_len[at-1] = LEN_BITS'(64'(ext_len[at-1]) + n + 64'(ext_len[at]));
      drop_extent(at);
    end else if (join_lo) begin
      ext_len[at-1] = LEN_BITS'(64'(ext_len[at-1]) + n);
    end else if (join_hi) begin
      ext_start[at] = s[ADDR_BITS-1:0];
      ext_len[at]   = LEN_BITS'(64'(ext_len[at]) + n);
    end else begin
      if (ext_count >= HOLE_SLOTS) return ST_FRAGMENTED;
      add_extent(at, s, n);
    end
    return ST_OK;
  endfunction

  // First fit with aligned start; head and tail remainders stay free
  function automatic status_t take_block(bit [63:0] want_bytes, output bit [63:0] grant);
    bit [63:0] hs;
    bit [63:0] hend;
    bit [63:0] pad;
    bit [63:0] astart;
    bit [63:0] tail;
    grant = 64'd0;
    if (want_bytes == 0) return ST_NO_SPACE;
    for (int unsigned i = 0; i < ext_count; i++) begin
      hs   = 64'(ext_start[i]);
      hend = hs + 64'(ext_len[i]);
      pad  = (64'(ALIGN_BYTES) - hs % 64'(ALIGN_BYTES)) % 64'(ALIGN_BYTES);
      if (hs > ADDR_LIMIT - pad) continue;
      astart = hs + pad;
      if (astart > hend || want_bytes > hend - astart) continue;
      tail = hend - astart - want_bytes;
      if (pad != 0 && tail != 0 && ext_count >= HOLE_SLOTS) return ST_FRAGMENTED;
      if (pad == 0 && tail == 0) begin
        drop_extent(i);
      end else if (pad == 0) begin
        ext_start[i] = ADDR_BITS'(astart + want_bytes);
        ext_len[i]   = LEN_BITS'(tail);
      end else begin
        ext_len[i] = LEN_BITS'(pad);
        if (tail != 0) add_extent(i + 1, astart + want_bytes, tail);
      end
      grant = astart;
      return ST_OK;
    end
    return ST_NO_SPACE;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void queue_item(bit kind, bit [63:0] s, bit [63:0] n);
    req_item_t it;
    it.kind       = kind;
    it.start      = s[ADDR_BITS-1:0];
    it.count      = n[LEN_BITS-1:0];
    it.wait_drain = drain_next;
    drain_next    = 1'b0;
    pending_reqs.push_back(it);
  endfunction

  function automatic void add_release(bit [63:0] s, bit [63:0] n);
    queue_item(REQ_RELEASE, s, n);
  endfunction

  // Start field is don't-care for a take, so it gets noise
  function automatic void add_take(bit [63:0] n);
    queue_item(REQ_TAKE, rand64(), n);
  endfunction

  // Mostly short pauses, now and then a long one
  function automatic int pause_length();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic void flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch in %s: expected %0h, got %0h", $realtime, what, want, got);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: one request transaction at a time from pending_reqs. The model is
  // stepped at the edge where the block accepts the transaction.
  // --------------------------------------------------------------------------
  req_item_t in_flight;
  int        idle_left = 0;

  always @(posedge clk) begin
    bit             took;
    extent_result_t want;
    bit [63:0]      grant;
    if (rst) begin
      drv_valid <= 1'b0;
      idle_left = 0;
    end else begin
      took = drv_valid && req_if.ready;
      if (took) begin
        grant = 64'd0;
        if (in_flight.kind == REQ_RELEASE) begin
          want.status = release_range(64'(in_flight.start), 64'(in_flight.count));
          n_releases++;
        end else begin
          want.status = take_block(64'(in_flight.count), grant);
          if (want.status != ST_OK) grant = 64'd0;
          n_takes++;
        end
        want.grant = grant[ADDR_BITS-1:0];
        want.holes = CNT_W'(ext_count);
        owed_results.push_back(want);
        status_count[want.status]++;
        if (ext_count > peak_holes) peak_holes = ext_count;
        n_accepted <= n_accepted + 1;
        idle_left = ($urandom_range(0, 9) < 5) ? 0 : pause_length();
      end
      if (drv_valid && !took) begin
        // hold the transaction until it is taken
      end else if (idle_left > 0) begin
        idle_left--;
        drv_valid <= 1'b0;
      end else if (pending_reqs.size() != 0 &&
                   (!pending_reqs[0].wait_drain || n_accepted + int'(took) == n_results)) begin
        in_flight = pending_reqs.pop_front();
        drv_valid <= 1'b1;
        drv_kind  <= in_flight.kind;
        drv_start <= in_flight.start;
        drv_count <= in_flight.count;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random back-pressure on rsp, in-order check of every result
  // --------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    extent_result_t want;
    if (rst) begin
      sink_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_if.valid && sink_ready) begin
        if (owed_results.size() == 0) begin
          flag_mismatch("result with nothing outstanding", 64'd0, 64'(rsp_if.status));
        end else begin
          want = owed_results.pop_front();
          if (rsp_if.status !== want.status)
            flag_mismatch("status", 64'(want.status), 64'(rsp_if.status));
          if (rsp_if.grant_address !== want.grant)
            flag_mismatch("grant_address", 64'(want.grant), 64'(rsp_if.grant_address));
          if (rsp_if.holes_in_use !== want.holes)
            flag_mismatch("holes_in_use", 64'(want.holes), 64'(rsp_if.holes_in_use));
        end
        n_results <= n_results + 1;
      end
      if (stall_left > 0) begin
        stall_left--;
        sink_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = pause_length() - 1;
        sink_ready <= 1'b0;
      end else begin
        sink_ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long with no transaction on either channel
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((drv_valid && req_if.ready) || (rsp_if.valid && sink_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] no transaction for %0d cycles, %0d results outstanding",
                 $realtime, quiet_cycles, owed_results.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus build, reset, end of test
  // --------------------------------------------------------------------------
  initial begin
    bit [63:0]   top;
    bit [63:0]   big;
    bit [63:0]   half;
    bit [63:0]   base;
    bit [63:0]   l1;
    bit [63:0]   l2;
    bit [63:0]   frag_s [18];
    bit [63:0]   frag_e [18];
    int unsigned grain;
    int          n_directed;
    int          n_steps;
    bit          first_episode;

    for (int i = 0; i < 4; i++) status_count[i] = 0;

    // Directed opening on an empty table
    top  = ADDR_LIMIT;
    big  = 64'd1 << LEN_BITS;
    half = 64'd1 << (LEN_BITS - 1);
    add_take(0);                       // zero-byte take
    add_take(16);                      // nothing held yet
    add_release(64'h1234, 0);          // zero-length release
    add_release(top, 1);               // runs past the last address
    add_release(0, 'h100);
    add_release('h200, 'h100);
    add_release('h100, 'h100);         // joins both neighbors
    add_release('h80, 'h10);           // overlaps a held extent
    add_take('h10);                    // grant at address zero
    add_release('h300, 5);             // joins the extent below
    add_take('h2f5);                   // exact fit empties the table
    add_release(top - 5, 5);           // extent ending at the last address
    add_take(1);                       // aligned start past the top: skipped
    add_release('h1003, 'h40);
    add_take('h20);                    // splits off head and tail
    add_release('h1000, 3);            // joins the extent above
    add_release(big, half);
    add_release(big + half + 1, half);
    add_release(big + half, 1);        // both joins too long, lower one only
    add_release(big + big + 1, LEN_LIMIT);  // max length, cannot join below
    add_take(LEN_LIMIT);
    add_take(half);
    add_take(LEN_LIMIT >> 1);
    n_directed = pending_reqs.size();

    // Random episodes until the item budget is used up
    first_episode = 1'b1;
    while (pending_reqs.size() < n_directed + RANDOM_ITEMS) begin
      drain_next    = first_episode || ($urandom_range(0, 3) == 0);
      first_episode = 1'b0;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: begin
          // churn inside a small window: joins, overlaps, splits
          case ($urandom_range(0, 2))
            0:       base = 64'($urandom_range(0, 255)) << 12;
            1:       base = rand64() & ADDR_LIMIT & ~64'hfff;
            default: base = ADDR_LIMIT - 64'($urandom_range(4096, 1 << 20));
          endcase
          grain   = $urandom_range(1, 48);
          n_steps = $urandom_range(10, 30);
          for (int k = 0; k < n_steps; k++) begin
            if ($urandom_range(0, 99) < 55)
              add_release(base + grain * $urandom_range(0, 40) +
                          (($urandom_range(0, 7) == 0) ? $urandom_range(0, grain - 1) : 0),
                          grain * $urandom_range(1, 3));
            else
              add_take(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3 * grain));
          end
        end
        8, 9, 10, 11: begin
          // fill the table with disjoint unaligned extents, overflow it,
          // force split refusals, then close gaps so extents coalesce
          base = 64'($urandom_range(1, 4095)) << 20;
          for (int k = 0; k < 18; k++) begin
            frag_s[k] = base + 64 * k + $urandom_range(0, 7);
            frag_e[k] = frag_s[k] + $urandom_range(16, 40);
            add_release(frag_s[k], frag_e[k] - frag_s[k]);
          end
          for (int k = 0; k < 3; k++) add_take($urandom_range(1, 8));
          for (int k = 0; k < 17; k++)
            if ($urandom_range(0, 2) != 0) add_release(frag_e[k], frag_s[k+1] - frag_e[k]);
          for (int k = 0; k < 3; k++) add_take($urandom_range(32, 200));
        end
        12, 13, 14: begin
          // lengths near the top of the length field
          base = 64'($urandom_range(1, 65535)) << 24;
          l1   = ($urandom_range(0, 1) != 0) ? LEN_LIMIT - $urandom_range(0, 2)
                                             : half + $urandom_range(0, 3);
          l2   = half + $urandom_range(0, 3);
          grain = $urandom_range(1, 4);
          add_release(base, l1);
          add_release(base + l1 + grain, l2);
          add_release(base + l1, grain);
          add_take(rand64() & LEN_LIMIT);
          add_take(l1);
          add_take($urandom_range(1, 64));
        end
        15, 16: begin
          // close to the end of the address space
          n_steps = $urandom_range(5, 10);
          for (int k = 0; k < n_steps; k++) begin
            if ($urandom_range(0, 2) != 0)
              add_release(ADDR_LIMIT - $urandom_range(0, 600), $urandom_range(1, 400));
            else
              add_take($urandom_range(1, 32));
          end
        end
        default: begin
          // raw noise over every field bit
          n_steps = $urandom_range(4, 10);
          for (int k = 0; k < n_steps; k++)
            queue_item(1'($urandom_range(0, 1)), rand64(), rand64());
        end
      endcase
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending_reqs.size() != 0 || drv_valid || n_accepted != n_results);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (owed_results.size() != 0) begin
      $display("%0d results never arrived", owed_results.size());
      mismatches += owed_results.size();
    end

    $display("Coverage: %0d releases, %0d takes; table peaked at %0d extents.",
             n_releases, n_takes, peak_holes);
    $display("Outcomes: ok %0d, no_space %0d, fragmented %0d, overlap %0d; mismatches %0d.",
             status_count[ST_OK], status_count[ST_NO_SPACE],
             status_count[ST_FRAGMENTED], status_count[ST_OVERLAP], mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/cfel_pkg.sv
hw/rtl/cfel_ifs.sv
hw/rtl/coalescing_free_extent_list.sv
tb/tb_top.sv
